// ----- hw/rtl/hsv2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types, constants and helpers for the HSV to RGB conversion pipeline.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int unsigned HUE_TURN    = 360;
  localparam int unsigned SECTOR_SPAN = 60;
  localparam int unsigned LEVEL_MAX   = 255;

  // floor(hue / 360) estimate: (hue * RECIP) >> RECIP_SHIFT, low by at most one
  localparam int unsigned RECIP_SHIFT = 22;
  localparam int unsigned RECIP       = (1 << RECIP_SHIFT) / HUE_TURN;

  // 255 / 60 is exactly 17 / 4
  localparam int unsigned FRAC_NUM   = 17;
  localparam int unsigned FRAC_SHIFT = 2;

  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_t;

  // hue split and value side levels, leaving the hue stages
  typedef struct packed {
    sector_t    sector;
    logic [7:0] frac;
    logic [7:0] sat;
    logic [7:0] val;
    logic [7:0] p;
  } sect_t;

  // products waiting for the final scaling, leaving the level stages
  typedef struct packed {
    sector_t     sector;
    logic        grey;
    logic [7:0]  val;
    logic [7:0]  p;
    logic [15:0] mq;
    logic [15:0] mt;
  } lvl_t;

  // floor(x / 255), exact for every x below 65536 that a product of two bytes gives
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [15:0] sum;
    sum = x + {8'd0, x[15:8]} + 16'd1;
    return sum[15:8];
  endfunction

endpackage

// ----- hw/rtl/hsv_to_rgb_converter_core.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core
// HSV to 8-bit RGB pixel converter, six-stage pipeline.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with in_hue_degrees (degrees, any 16-bit
// value, wrapped modulo 360), in_saturation and in_brightness.
// Result channel: out_valid / out_stall with out_red, out_green, out_blue.
// An item moves on a rising edge where valid is high and stall is low.
// Pipeline: six register stages, the first of which loads at the accepting
// edge (hue wrap multiply, remainder, sector split, saturation products,
// value products, final scaling and routing); out_valid rises once the item
// has been loaded into the last of them.
// Throughput: one item per clock, sustained while out_stall stays low.
// When the receiver stalls, the result holds in the output register and the
// stages behind it keep filling until every stage holds an item; only then
// does in_stall rise, so empty stages are squeezed out and nothing is lost.
// Reset (rst_n low, synchronous) empties every stage; no item is in flight
// after it and out_valid is low. There is no configuration and no state
// carried from one item to the next.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_hue_degrees,
  input  logic [7:0]  in_saturation,
  input  logic [7:0]  in_brightness,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue
);

  logic               sect_vld, sect_stall;
  hsv2rgb_pkg::sect_t sect_data;
  logic               lvl_vld, lvl_stall;
  hsv2rgb_pkg::lvl_t  lvl_data;

  hsv2rgb_sector u_sector (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (in_valid),
    .hue_i   (in_hue_degrees),
    .sat_i   (in_saturation),
    .val_i   (in_brightness),
    .stall_o (in_stall),
    .vld_o   (sect_vld),
    .data_o  (sect_data),
    .stall_i (sect_stall)
  );

  hsv2rgb_level u_level (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (sect_vld),
    .data_i  (sect_data),
    .stall_o (sect_stall),
    .vld_o   (lvl_vld),
    .data_o  (lvl_data),
    .stall_i (lvl_stall)
  );

  hsv2rgb_route u_route (
    .clk       (clk),
    .rst_n     (rst_n),
    .vld_i     (lvl_vld),
    .data_i    (lvl_data),
    .stall_o   (lvl_stall),
    .out_valid (out_valid),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_stall (out_stall)
  );

endmodule

// ----- hw/rtl/hsv2rgb_sector.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_sector
// Three stages: hue modulo 360, sector and rescaled offset, plus the p level.
// ----------------------------------------------------------------------------
module hsv2rgb_sector (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vld_i,
  input  logic [15:0]         hue_i,
  input  logic [7:0]          sat_i,
  input  logic [7:0]          val_i,
  output logic                stall_o,
  output logic                vld_o,
  output hsv2rgb_pkg::sect_t  data_o,
  input  logic                stall_i
);

  // stage 1
  logic        vld1_r, vld1_nxt;
  logic [15:0] hue1_r;
  logic [7:0]  qest1_r, sat1_r, val1_r;
  logic [15:0] pm1_r;
  // stage 2
  logic        vld2_r, vld2_nxt;
  logic [8:0]  h2_r;
  logic [7:0]  sat2_r, val2_r, p2_r;
  // stage 3
  logic        vld3_r, vld3_nxt;
  hsv2rgb_pkg::sect_t s3_r;

  logic en1, en2, en3;

  logic [29:0] hue_prod;
  logic [16:0] qbase;
  logic [16:0] hdiff;
  logic [8:0]  h_mod;
  hsv2rgb_pkg::sector_t sec;
  logic [8:0]  sbase;
  logic [8:0]  offset;
  logic [9:0]  frac_prod;

  // a stage moves when it is empty or the next one moves
  assign en3     = !vld3_r || !stall_i;
  assign en2     = !vld2_r || en3;
  assign en1     = !vld1_r || en2;
  assign stall_o = !en1;

  assign vld1_nxt = en1 ? vld_i  : vld1_r;
  assign vld2_nxt = en2 ? vld1_r : vld2_r;
  assign vld3_nxt = en3 ? vld2_r : vld3_r;

  assign hue_prod = 30'(hue_i) * 30'(hsv2rgb_pkg::RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      vld1_r <= vld1_nxt;
      vld2_r <= vld2_nxt;
      vld3_r <= vld3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      hue1_r  <= hue_i;
      qest1_r <= hue_prod[hsv2rgb_pkg::RECIP_SHIFT +: 8];
      sat1_r  <= sat_i;
      val1_r  <= val_i;
      pm1_r   <= 16'(val_i) * {8'd0, ~sat_i};
    end
  end

  // remainder from the quotient estimate, one correction step
  always_comb begin
    qbase = 17'(qest1_r) * 17'(hsv2rgb_pkg::HUE_TURN);
    hdiff = {1'b0, hue1_r} - qbase;
    if (hdiff >= 17'(hsv2rgb_pkg::HUE_TURN)) begin
      hdiff = hdiff - 17'(hsv2rgb_pkg::HUE_TURN);
    end
    h_mod = hdiff[8:0];
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      h2_r   <= h_mod;
      sat2_r <= sat1_r;
      val2_r <= val1_r;
      p2_r   <= hsv2rgb_pkg::div255(pm1_r);
    end
  end

  always_comb begin
    priority if (h2_r >= 9'(5 * hsv2rgb_pkg::SECTOR_SPAN)) begin
      sec   = hsv2rgb_pkg::SEC_MAGENTA;
      sbase = 9'(5 * hsv2rgb_pkg::SECTOR_SPAN);
    end else if (h2_r >= 9'(4 * hsv2rgb_pkg::SECTOR_SPAN)) begin
      sec   = hsv2rgb_pkg::SEC_BLUE;
      sbase = 9'(4 * hsv2rgb_pkg::SECTOR_SPAN);
    end else if (h2_r >= 9'(3 * hsv2rgb_pkg::SECTOR_SPAN)) begin
      sec   = hsv2rgb_pkg::SEC_CYAN;
      sbase = 9'(3 * hsv2rgb_pkg::SECTOR_SPAN);
    end else if (h2_r >= 9'(2 * hsv2rgb_pkg::SECTOR_SPAN)) begin
      sec   = hsv2rgb_pkg::SEC_GREEN;
      sbase = 9'(2 * hsv2rgb_pkg::SECTOR_SPAN);
    end else if (h2_r >= 9'(hsv2rgb_pkg::SECTOR_SPAN)) begin
      sec   = hsv2rgb_pkg::SEC_YELLOW;
      sbase = 9'(hsv2rgb_pkg::SECTOR_SPAN);
    end else begin
      sec   = hsv2rgb_pkg::SEC_RED;
      sbase = 9'd0;
    end
    offset    = h2_r - sbase;
    frac_prod = 10'(offset[5:0]) * 10'(hsv2rgb_pkg::FRAC_NUM);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_r.sector <= sec;
      s3_r.frac   <= 8'(frac_prod >> hsv2rgb_pkg::FRAC_SHIFT);
      s3_r.sat    <= sat2_r;
      s3_r.val    <= val2_r;
      s3_r.p      <= p2_r;
    end
  end

  assign vld_o  = vld3_r;
  assign data_o = s3_r;

  a_hue_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    vld2_r |-> h2_r < 9'(hsv2rgb_pkg::HUE_TURN))
    else $error("reduced hue out of range");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld3_r |-> s3_r.frac <= 8'(hsv2rgb_pkg::LEVEL_MAX - 5))
    else $error("sector offset rescale out of range");

endmodule

// ----- hw/rtl/hsv2rgb_level.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_level
// Two stages: saturation products with the offset, then the value products.
// ----------------------------------------------------------------------------
module hsv2rgb_level (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vld_i,
  input  hsv2rgb_pkg::sect_t  data_i,
  output logic                stall_o,
  output logic                vld_o,
  output hsv2rgb_pkg::lvl_t   data_o,
  input  logic                stall_i
);

  logic        vld4_r, vld4_nxt;
  hsv2rgb_pkg::sector_t sec4_r;
  logic [7:0]  val4_r, p4_r;
  logic        grey4_r;
  logic [15:0] mf4_r, mg4_r;

  logic        vld5_r, vld5_nxt;
  hsv2rgb_pkg::lvl_t l5_r;

  logic en4, en5;
  logic [7:0] sf, sg;

  assign en5     = !vld5_r || !stall_i;
  assign en4     = !vld4_r || en5;
  assign stall_o = !en4;

  assign vld4_nxt = en4 ? vld_i  : vld4_r;
  assign vld5_nxt = en5 ? vld4_r : vld5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
    end else begin
      vld4_r <= vld4_nxt;
      vld5_r <= vld5_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      sec4_r  <= data_i.sector;
      val4_r  <= data_i.val;
      p4_r    <= data_i.p;
      grey4_r <= (data_i.sat == 8'd0);
      mf4_r   <= 16'(data_i.sat) * 16'(data_i.frac);
      mg4_r   <= 16'(data_i.sat) * {8'd0, ~data_i.frac};
    end
  end

  assign sf = hsv2rgb_pkg::div255(mf4_r);
  assign sg = hsv2rgb_pkg::div255(mg4_r);

  always_ff @(posedge clk) begin
    if (en5) begin
      l5_r.sector <= sec4_r;
      l5_r.grey   <= grey4_r;
      l5_r.val    <= val4_r;
      l5_r.p      <= p4_r;
      l5_r.mq     <= 16'(val4_r) * {8'd0, ~sf};
      l5_r.mt     <= 16'(val4_r) * {8'd0, ~sg};
    end
  end

  assign vld_o  = vld5_r;
  assign data_o = l5_r;

  a_p_below_v: assert property (@(posedge clk) disable iff (!rst_n)
    vld5_r |-> l5_r.p <= l5_r.val)
    else $error("p level above value");

endmodule

// ----- hw/rtl/hsv2rgb_route.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_route
// Output stage: final scaling of q and t, routing by sector (a grey item gives v
// on all three channels), result register.
module hsv2rgb_route (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               vld_i,
  input  hsv2rgb_pkg::lvl_t  data_i,
  output logic               stall_o,
  output logic               out_valid,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  input  logic               out_stall
);

  logic       vld_r, vld_nxt;
  logic [7:0] red_r, green_r, blue_r;
  logic [7:0] red_nxt, green_nxt, blue_nxt;
  logic [7:0] q, t, v, p;
  logic       en;

  assign en      = !vld_r || !out_stall;
  assign stall_o = !en;
  assign vld_nxt = en ? vld_i : vld_r;

  assign q = hsv2rgb_pkg::div255(data_i.mq);
  assign t = hsv2rgb_pkg::div255(data_i.mt);
  assign v = data_i.val;
  assign p = data_i.p;

  always_comb begin
    if (data_i.grey) begin
      red_nxt   = v;
      green_nxt = v;
      blue_nxt  = v;
    end else begin
      unique case (data_i.sector)
        hsv2rgb_pkg::SEC_RED: begin
          red_nxt = v; green_nxt = t; blue_nxt = p;
        end
        hsv2rgb_pkg::SEC_YELLOW: begin
          red_nxt = q; green_nxt = v; blue_nxt = p;
        end
        hsv2rgb_pkg::SEC_GREEN: begin
          red_nxt = p; green_nxt = v; blue_nxt = t;
        end
        hsv2rgb_pkg::SEC_CYAN: begin
          red_nxt = p; green_nxt = q; blue_nxt = v;
        end
        hsv2rgb_pkg::SEC_BLUE: begin
          red_nxt = t; green_nxt = p; blue_nxt = v;
        end
        default: begin
          red_nxt = v; green_nxt = p; blue_nxt = q;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld_i |=> vld_r)
    else $error("item lost at output register");

  a_grey_equal: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld_i && data_i.grey |=> red_r == green_r && green_r == blue_r)
    else $error("grey item with unequal channels");

endmodule
